/* design/ddoi_pkg.sv */
// shared constants, types and the arctangent table of the odometry integrator
`default_nettype none

package ddoi_pkg;

	// fixed-point format and cordic length
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int COR_CNT_W    = $clog2(CORDIC_STEPS);

	// field widths
	localparam int SPEED_W = 16;
	localparam int US_W    = 20;
	localparam int DIAM_W  = 16;
	localparam int TRACK_W = 18;
	localparam int POS_W   = 48;
	localparam int ANG_W   = 32;
	localparam int RATE_W  = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_DIAM  = 2'd0,
		REG_RIGHT_DIAM = 2'd1,
		REG_TRACK      = 2'd2
	} cfg_reg_t;

	// bit-serial multiplier
	localparam int MUL_A_W   = 34;
	localparam int MUL_B_W   = 32;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// restoring divider
	localparam int DIV_NUM_W = (FRAC_BITS + 35 > 56) ? FRAC_BITS + 35 : 56;
	localparam int DIV_DEN_W = 24;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// cordic datapath
	localparam int CV_W = 34;
	localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032875;

	// arithmetic constants
	localparam logic [MUL_B_W-1:0]   BAM_PER_RAD = 32'd683565276;
	localparam logic [DIV_DEN_W-1:0] US_PER_S    = 24'd1000000;
	localparam logic [DIV_DEN_W-1:0] FWD_DIVISOR = 24'd100;
	localparam int                   TRACK_SCALE = 50;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_L,
		S_MUL_R,
		S_DIV_F,
		S_DIV_T,
		S_COR,
		S_MUL_PX,
		S_MUL_PY,
		S_MUL_DX,
		S_DIV_DX,
		S_MUL_DY,
		S_DIV_DY,
		S_MUL_TH,
		S_DIV_TH,
		S_MUL_BAM,
		S_DONE
	} odo_state_t;

	// atan(2^-i) as a binary angle, 2^32 per turn
	function automatic logic [ANG_W-1:0] atan_bam(input logic [4:0] i);
		logic [ANG_W-1:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			5'd31: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/ddoi_in_if.sv */
// input channel: raw wheel speeds and elapsed time
`default_nettype none

interface ddoi_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ddoi_pkg::SPEED_W-1:0]  left_raw_speed;
	logic signed [ddoi_pkg::SPEED_W-1:0]  right_raw_speed;
	logic        [ddoi_pkg::US_W-1:0]     elapsed_us;

	modport source (output valid, left_raw_speed, right_raw_speed, elapsed_us, input ready);
	modport sink   (input valid, left_raw_speed, right_raw_speed, elapsed_us, output ready);
endinterface

`default_nettype wire

/* design/ddoi_out_if.sv */
// output channel: pose and speeds after an update
`default_nettype none

interface ddoi_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ddoi_pkg::POS_W-1:0]   pos_x;
	logic signed [ddoi_pkg::POS_W-1:0]   pos_y;
	logic        [ddoi_pkg::ANG_W-1:0]   heading;
	logic signed [ddoi_pkg::RATE_W-1:0]  forward_speed;
	logic signed [ddoi_pkg::RATE_W-1:0]  turn_rate;

	modport source (output valid, pos_x, pos_y, heading, forward_speed, turn_rate,
		input ready);
	modport sink   (input valid, pos_x, pos_y, heading, forward_speed, turn_rate,
		output ready);
endinterface

`default_nettype wire

/* design/ddoi_mul.sv */
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module ddoi_mul (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [ddoi_pkg::MUL_A_W-1:0]     a,
	input  wire logic [ddoi_pkg::MUL_B_W-1:0]     b,
	output logic                                  done,
	output logic      [ddoi_pkg::MUL_P_W-1:0]     p
);

	logic [ddoi_pkg::MUL_A_W-1:0]   a_q;
	logic [ddoi_pkg::MUL_P_W-1:0]   p_q;
	logic [ddoi_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ddoi_pkg::MUL_A_W:0]     hi_sum;

	// add the multiplicand into the upper half when the low bit is set
	assign hi_sum = {1'b0, p_q[ddoi_pkg::MUL_P_W-1:ddoi_pkg::MUL_B_W]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ddoi_pkg::MUL_CNT_W'(ddoi_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{ddoi_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {hi_sum, p_q[ddoi_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

`default_nettype wire

/* design/ddoi_div.sv */
// restoring divider with round-half-up on magnitudes, one quotient bit per cycle
`default_nettype none

module ddoi_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [ddoi_pkg::DIV_NUM_W-1:0]   num,
	input  wire logic [ddoi_pkg::DIV_DEN_W-1:0]   den,
	output logic                                  done,
	output logic      [ddoi_pkg::DIV_NUM_W-1:0]   quo
);

	logic [ddoi_pkg::DIV_NUM_W-1:0] n_q;
	logic [ddoi_pkg::DIV_DEN_W-1:0] den_q;
	logic [ddoi_pkg::DIV_DEN_W-1:0] rem_q;
	logic [ddoi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ddoi_pkg::DIV_DEN_W:0]   rem_sh;
	logic [ddoi_pkg::DIV_DEN_W:0]   rem_sub;
	logic                           ge;

	// trial subtract of the shifted remainder
	assign rem_sh  = {rem_q, n_q[ddoi_pkg::DIV_NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ddoi_pkg::DIV_CNT_W'(ddoi_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num + ddoi_pkg::DIV_NUM_W'(den >> 1);
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[ddoi_pkg::DIV_DEN_W-1:0] : rem_sh[ddoi_pkg::DIV_DEN_W-1:0];
			n_q   <= {n_q[ddoi_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

`default_nettype wire

/* design/ddoi_cordic.sv */
// iterative cordic rotation giving cosine and sine of a binary angle, one step per cycle
`default_nettype none

module ddoi_cordic (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic        [ddoi_pkg::ANG_W-1:0]  angle,
	output logic                                    done,
	output logic signed      [ddoi_pkg::CV_W-1:0]   cos_o,
	output logic signed      [ddoi_pkg::CV_W-1:0]   sin_o
);

	logic signed [ddoi_pkg::CV_W-1:0]    x_q;
	logic signed [ddoi_pkg::CV_W-1:0]    y_q;
	logic signed [ddoi_pkg::ANG_W:0]     z_q;
	logic        [ddoi_pkg::COR_CNT_W-1:0] i_q;
	logic                                flip_q;
	logic                                busy_q;
	logic                                done_q;
	logic signed [ddoi_pkg::CV_W-1:0]    xs;
	logic signed [ddoi_pkg::CV_W-1:0]    ys;
	logic signed [ddoi_pkg::ANG_W:0]     at;
	logic                                flip_in;
	logic        [ddoi_pkg::ANG_W-1:0]   ang_in;

	// left half plane is folded by half a turn
	assign flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
	assign ang_in  = flip_in ? angle - 32'h80000000 : angle;

	// shifted terms of this step
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({1'b0, ddoi_pkg::atan_bam(5'(i_q))});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == ddoi_pkg::COR_CNT_W'(ddoi_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ddoi_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= $signed({ang_in[31], ang_in});
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (!z_q[ddoi_pkg::ANG_W]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

/* design/diff_drive_odometry_integrator.sv */
// differential-drive odometry integrator: sequencer, configuration and pose state
// Each transaction with nonzero elapsed time yields one pose update; zero elapsed time is
// dropped with no result. An update runs through the bit-serial multiplier (eight products),
// the restoring divider (five quotients) and the cordic, then loads the result; one item is
// in work at a time and the next one is taken as soon as the result sits in the output
// register. Configuration is to be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Unknown indexes are ignored, zero track
// width counts as one LSB. Position is Q31.16 and wraps, heading is a binary angle (2^32
// per turn).
`default_nettype none

module diff_drive_odometry_integrator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	ddoi_in_if.sink                                 sample,
	ddoi_out_if.source                              pose,
	input  wire logic                               cfg_we,
	input  wire logic [ddoi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ddoi_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int F = ddoi_pkg::FRAC_BITS;
	localparam int AW = ddoi_pkg::MUL_A_W;
	localparam int BW = ddoi_pkg::MUL_B_W;
	localparam int PW = ddoi_pkg::MUL_P_W;
	localparam int NW = ddoi_pkg::DIV_NUM_W;

	ddoi_pkg::odo_state_t state_q, state_d;

	logic [ddoi_pkg::DIAM_W-1:0]  ldiam_q, rdiam_q;
	logic [ddoi_pkg::TRACK_W-1:0] track_q;

	logic signed [16:0]           lraw_q, rraw_q;
	logic [ddoi_pkg::US_W-1:0]    us_q;
	logic signed [AW-1:0]         lp_q, rp_q, px_q, py_q, dth_q;
	logic signed [31:0]           fwd_q, turn_q;
	logic signed [ddoi_pkg::POS_W-1:0] dx_q, dy_q;
	logic [ddoi_pkg::ANG_W-1:0]   dbam_q;

	logic signed [ddoi_pkg::POS_W-1:0] x_q, y_q;
	logic [ddoi_pkg::ANG_W-1:0]        heading_q;

	logic                         out_valid_q;
	logic signed [ddoi_pkg::POS_W-1:0] out_x_q, out_y_q;
	logic [ddoi_pkg::ANG_W-1:0]   out_h_q;
	logic signed [31:0]           out_f_q, out_t_q;

	logic                         launched_q;
	logic                         mul_start, div_start, cor_start;
	logic                         mul_done, div_done, cor_done;
	logic [AW-1:0]                mul_a;
	logic [BW-1:0]                mul_b;
	logic [PW-1:0]                mul_p;
	logic [NW-1:0]                div_num, div_quo;
	logic [ddoi_pkg::DIV_DEN_W-1:0] div_den, track_den;
	logic signed [ddoi_pkg::CV_W-1:0] cor_c, cor_s;
	logic                         out_load;
	logic                         accept;

	logic signed [AW-1:0]         sum_w, diff_w;
	logic [PW-1:0]                rnd30, rndf;
	logic [AW-1:0]                pmag30;
	logic [31:0]                  bam_mag;

	// magnitude of a signed datapath word
	function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
		return v[AW-1] ? AW'(-v) : AW'(v);
	endfunction

	// apply sign to a quotient magnitude and saturate to 32 bits
	function automatic logic signed [31:0] sat32(input logic neg, input logic [NW-1:0] q);
		logic signed [31:0] r;
		if (neg) begin
			r = (q > NW'(33'h080000000)) ? 32'sh80000000 : -$signed(q[31:0]);
		end else begin
			r = (q > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
		end
		return r;
	endfunction

	assign accept = sample.valid && sample.ready;

	// wheel sum and difference
	assign sum_w  = lp_q + rp_q;
	assign diff_w = rp_q - lp_q;

	// divisor for turn rate, zero width treated as one lsb
	assign track_den = ddoi_pkg::DIV_DEN_W'((track_q == '0) ? 18'd1 : track_q)
		* ddoi_pkg::DIV_DEN_W'(ddoi_pkg::TRACK_SCALE);

	// power-of-two rounding of products
	assign rnd30   = mul_p + (PW'(1) << 29);
	assign pmag30  = rnd30[AW+29:30];
	assign rndf    = mul_p + (PW'(1) << (F - 1));
	assign bam_mag = rndf[F+31:F];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ldiam_q <= 16'd6554;
			rdiam_q <= 16'd6554;
			track_q <= 18'd25821;
		end else if (cfg_we) begin
			case (cfg_index)
				ddoi_pkg::REG_LEFT_DIAM:  ldiam_q <= cfg_data[ddoi_pkg::DIAM_W-1:0];
				ddoi_pkg::REG_RIGHT_DIAM: rdiam_q <= cfg_data[ddoi_pkg::DIAM_W-1:0];
				ddoi_pkg::REG_TRACK:      track_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state register and launch flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ddoi_pkg::S_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			launched_q <= (state_d == state_q)
				? (launched_q | mul_start | div_start | cor_start) : 1'b0;
		end
	end

	// next state and unit operands
	always_comb begin
		state_d      = state_q;
		mul_start    = 1'b0;
		div_start    = 1'b0;
		cor_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_num      = '0;
		div_den      = '0;
		out_load     = 1'b0;
		sample.ready = 1'b0;
		unique case (state_q)
			ddoi_pkg::S_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid && (sample.elapsed_us != '0)) state_d = ddoi_pkg::S_MUL_L;
			end
			ddoi_pkg::S_MUL_L: begin
				mul_a     = mag(AW'(lraw_q));
				mul_b     = BW'(ldiam_q);
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_MUL_R;
			end
			ddoi_pkg::S_MUL_R: begin
				mul_a     = mag(AW'(rraw_q));
				mul_b     = BW'(rdiam_q);
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_DIV_F;
			end
			ddoi_pkg::S_DIV_F: begin
				div_num   = NW'(mag(sum_w));
				div_den   = ddoi_pkg::FWD_DIVISOR;
				div_start = !launched_q;
				if (div_done) state_d = ddoi_pkg::S_DIV_T;
			end
			ddoi_pkg::S_DIV_T: begin
				div_num   = NW'(mag(diff_w)) << F;
				div_den   = track_den;
				div_start = !launched_q;
				if (div_done) state_d = ddoi_pkg::S_COR;
			end
			ddoi_pkg::S_COR: begin
				cor_start = !launched_q;
				if (cor_done) state_d = ddoi_pkg::S_MUL_PX;
			end
			ddoi_pkg::S_MUL_PX: begin
				mul_a     = mag(AW'(fwd_q));
				mul_b     = BW'(mag(cor_c));
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_MUL_PY;
			end
			ddoi_pkg::S_MUL_PY: begin
				mul_a     = mag(AW'(fwd_q));
				mul_b     = BW'(mag(cor_s));
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_MUL_DX;
			end
			ddoi_pkg::S_MUL_DX: begin
				mul_a     = mag(px_q);
				mul_b     = BW'(us_q);
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_DIV_DX;
			end
			ddoi_pkg::S_DIV_DX: begin
				div_num   = mul_p[NW-1:0];
				div_den   = ddoi_pkg::US_PER_S;
				div_start = !launched_q;
				if (div_done) state_d = ddoi_pkg::S_MUL_DY;
			end
			ddoi_pkg::S_MUL_DY: begin
				mul_a     = mag(py_q);
				mul_b     = BW'(us_q);
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_DIV_DY;
			end
			ddoi_pkg::S_DIV_DY: begin
				div_num   = mul_p[NW-1:0];
				div_den   = ddoi_pkg::US_PER_S;
				div_start = !launched_q;
				if (div_done) state_d = ddoi_pkg::S_MUL_TH;
			end
			ddoi_pkg::S_MUL_TH: begin
				mul_a     = mag(AW'(turn_q));
				mul_b     = BW'(us_q);
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_DIV_TH;
			end
			ddoi_pkg::S_DIV_TH: begin
				div_num   = mul_p[NW-1:0];
				div_den   = ddoi_pkg::US_PER_S;
				div_start = !launched_q;
				if (div_done) state_d = ddoi_pkg::S_MUL_BAM;
			end
			ddoi_pkg::S_MUL_BAM: begin
				mul_a     = mag(dth_q);
				mul_b     = ddoi_pkg::BAM_PER_RAD;
				mul_start = !launched_q;
				if (mul_done) state_d = ddoi_pkg::S_DONE;
			end
			ddoi_pkg::S_DONE: begin
				if (!out_valid_q || pose.ready) begin
					out_load = 1'b1;
					state_d  = ddoi_pkg::S_IDLE;
				end
			end
		endcase
	end

	// capture of intermediate results
	always_ff @(posedge clk) begin
		if (accept) begin
			lraw_q <= 17'(sample.left_raw_speed);
			rraw_q <= -17'(sample.right_raw_speed);
			us_q   <= sample.elapsed_us;
		end
		if (mul_done) begin
			unique case (state_q)
				ddoi_pkg::S_MUL_L:
					lp_q <= lraw_q[16] ? -$signed(mul_p[AW-1:0]) : $signed(mul_p[AW-1:0]);
				ddoi_pkg::S_MUL_R:
					rp_q <= rraw_q[16] ? -$signed(mul_p[AW-1:0]) : $signed(mul_p[AW-1:0]);
				ddoi_pkg::S_MUL_PX:
					px_q <= (fwd_q[31] ^ cor_c[ddoi_pkg::CV_W-1])
						? -$signed(pmag30) : $signed(pmag30);
				ddoi_pkg::S_MUL_PY:
					py_q <= (fwd_q[31] ^ cor_s[ddoi_pkg::CV_W-1])
						? -$signed(pmag30) : $signed(pmag30);
				ddoi_pkg::S_MUL_BAM:
					dbam_q <= dth_q[AW-1] ? -bam_mag : bam_mag;
				default: ;
			endcase
		end
		if (div_done) begin
			unique case (state_q)
				ddoi_pkg::S_DIV_F:  fwd_q  <= sat32(sum_w[AW-1], div_quo);
				ddoi_pkg::S_DIV_T:  turn_q <= sat32(diff_w[AW-1], div_quo);
				ddoi_pkg::S_DIV_DX:
					dx_q <= px_q[AW-1] ? -$signed(div_quo[ddoi_pkg::POS_W-1:0])
						: $signed(div_quo[ddoi_pkg::POS_W-1:0]);
				ddoi_pkg::S_DIV_DY:
					dy_q <= py_q[AW-1] ? -$signed(div_quo[ddoi_pkg::POS_W-1:0])
						: $signed(div_quo[ddoi_pkg::POS_W-1:0]);
				ddoi_pkg::S_DIV_TH:
					dth_q <= turn_q[31] ? -$signed(div_quo[AW-1:0]) : $signed(div_quo[AW-1:0]);
				default: ;
			endcase
		end
	end

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else if (out_load) begin
			x_q       <= x_q + dx_q;
			y_q       <= y_q + dy_q;
			heading_q <= heading_q + dbam_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pose.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= x_q + dx_q;
			out_y_q <= y_q + dy_q;
			out_h_q <= heading_q + dbam_q;
			out_f_q <= fwd_q;
			out_t_q <= turn_q;
		end
	end

	assign pose.valid         = out_valid_q;
	assign pose.pos_x         = out_x_q;
	assign pose.pos_y         = out_y_q;
	assign pose.heading       = out_h_q;
	assign pose.forward_speed = out_f_q;
	assign pose.turn_rate     = out_t_q;

	// shared arithmetic units
	ddoi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	ddoi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ddoi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (heading_q),
		.done   (cor_done),
		.cos_o  (cor_c),
		.sin_o  (cor_s)
	);

	// multiplier finishes only inside a multiply step
	a_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ddoi_pkg::S_MUL_L || state_q == ddoi_pkg::S_MUL_R
			|| state_q == ddoi_pkg::S_MUL_PX || state_q == ddoi_pkg::S_MUL_PY
			|| state_q == ddoi_pkg::S_MUL_DX || state_q == ddoi_pkg::S_MUL_DY
			|| state_q == ddoi_pkg::S_MUL_TH || state_q == ddoi_pkg::S_MUL_BAM))
		else $error("multiplier done outside a multiply step");

	// cordic finishes only in its own step
	a_cor_state: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ddoi_pkg::S_COR))
		else $error("cordic done outside its step");

	// zero elapsed time never produces a result
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (sample.elapsed_us == '0) && !out_valid_q) |=> !out_valid_q)
		else $error("result produced for zero elapsed time");

	// a waiting result matches the held heading
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_h_q == heading_q))
		else $error("held result diverges from pose state");

endmodule

`default_nettype wire
